/* hw/rtl/kts_pkg.sv */
// Shared types, codes and keyword tables for the keyword token scanner.
package kts_pkg;

  localparam int unsigned POSITION_BITS = 16;
  localparam int unsigned LENGTH_MAX    = 255;

  // Result queue depth; two results may enter per cycle.
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned KW_COUNT = 10;

  typedef enum logic [1:0] {
    MODE_START   = 2'd0,
    MODE_IDENT   = 2'd1,
    MODE_NUMBER  = 2'd2,
    MODE_COMMENT = 2'd3
  } scan_mode_t;

  localparam logic [3:0] KIND_EOF    = 4'd0;
  localparam logic [3:0] KIND_IDENT  = 4'd11;
  localparam logic [3:0] KIND_NUMBER = 4'd12;
  localparam logic [3:0] KIND_CHAR   = 4'd13;

  localparam logic [KW_COUNT-1:0] ALL_MATCH = '1;

  // Config register indexes.
  localparam logic CFG_INITIAL_LINE   = 1'b0;
  localparam logic CFG_INITIAL_COLUMN = 1'b1;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // Keywords, right-justified: first char is the highest used byte.
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    "function", "return", "extern", "if", "else",
    "for", "in", "binary", "unary", "var"
  };
  localparam int unsigned KW_LEN [KW_COUNT] = '{8, 6, 6, 2, 4, 3, 2, 6, 5, 3};

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [7:0]  token_char;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [7:0]  lexeme_length;
    logic        last_of_run;
  } result_t;

  // Up to two results per consumed word, in order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // Byte p of keyword k (p must be below the keyword length).
  function automatic logic [7:0] kw_byte(input int unsigned k, input logic [2:0] p);
    logic [2:0] idx;
    idx = 3'(KW_LEN[k] - 1 - int'(p));
    return KW_TEXT[k][{idx, 3'b000} +: 8];
  endfunction

endpackage

/* hw/rtl/kts_scan.sv */
// Scanner state and per-character token logic.
module kts_scan #(
  parameter int unsigned POS_W   = kts_pkg::POSITION_BITS,
  parameter int unsigned LEN_MAX = kts_pkg::LENGTH_MAX
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       char_code,
  input  logic             end_of_input,
  input  logic [15:0]      initial_line,
  input  logic [15:0]      initial_column,
  output kts_pkg::push_t   push
);

  localparam int unsigned LEN_W = $clog2(LEN_MAX + 1);
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(LEN_MAX);

  kts_pkg::scan_mode_t mode, mode_next;
  logic [kts_pkg::KW_COUNT-1:0] kw_match, kw_match_next;
  logic [LEN_W-1:0] lex_count, lex_count_next;
  logic [POS_W-1:0] line_cnt, line_cnt_next;
  logic [POS_W-1:0] col_cnt, col_cnt_next;
  logic [POS_W-1:0] tok_line, tok_line_next;
  logic [POS_W-1:0] tok_col, tok_col_next;

  function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [POS_W-1:0] pos_clip(input logic [15:0] v);
    if (32'(v) > 32'(POS_MAX)) return POS_MAX;
    return POS_W'(v);
  endfunction

  logic is_nl, is_alpha, is_digit, is_space, is_under, is_dot, is_hash;
  logic word_open, cont, begin_word, single;
  logic [POS_W-1:0] line_adv, col_adv;
  logic [kts_pkg::KW_COUNT-1:0] base_match, hit, ext_match;
  logic [LEN_W-1:0] base_cnt, ext_cnt;
  logic [3:0] word_kind;
  kts_pkg::result_t res_a, res_b;
  logic have_a, have_b;

  assign is_nl    = (char_code == kts_pkg::CH_LF) || (char_code == kts_pkg::CH_CR);
  assign is_alpha = ((char_code >= 8'h41) && (char_code <= 8'h5A)) ||
                    ((char_code >= 8'h61) && (char_code <= 8'h7A));
  assign is_digit = (char_code >= 8'h30) && (char_code <= 8'h39);
  assign is_space = (char_code == kts_pkg::CH_SPACE) ||
                    ((char_code >= kts_pkg::CH_TAB) && (char_code <= kts_pkg::CH_CR));
  assign is_under = (char_code == kts_pkg::CH_UNDER);
  assign is_dot   = (char_code == kts_pkg::CH_DOT);
  assign is_hash  = (char_code == kts_pkg::CH_HASH);

  assign word_open  = (mode == kts_pkg::MODE_IDENT) || (mode == kts_pkg::MODE_NUMBER);
  assign cont       = ((mode == kts_pkg::MODE_IDENT) && (is_alpha || is_digit || is_under)) ||
                      ((mode == kts_pkg::MODE_NUMBER) && (is_digit || is_dot));
  assign begin_word = is_alpha || is_under || is_digit || is_dot;
  assign single     = !is_space && !begin_word && !is_hash;

  assign line_adv = is_nl ? pos_inc(line_cnt) : line_cnt;
  assign col_adv  = is_nl ? '0 : pos_inc(col_cnt);

  // Lexeme extension: continue the open word, or start a fresh one.
  assign base_match = cont ? kw_match : kts_pkg::ALL_MATCH;
  assign base_cnt   = cont ? lex_count : '0;

  always_comb begin
    for (int k = 0; k < kts_pkg::KW_COUNT; k++) begin
      hit[k] = (32'(base_cnt) < kts_pkg::KW_LEN[k]) &&
               (kts_pkg::kw_byte(k, base_cnt[2:0]) == char_code);
    end
  end

  assign ext_match = base_match & hit;
  assign ext_cnt   = (base_cnt == LEN_SAT) ? base_cnt : base_cnt + 1'b1;

  // Lowest keyword index wins.
  always_comb begin
    word_kind = (mode == kts_pkg::MODE_IDENT) ? kts_pkg::KIND_IDENT : kts_pkg::KIND_NUMBER;
    if (mode == kts_pkg::MODE_IDENT) begin
      for (int k = kts_pkg::KW_COUNT - 1; k >= 0; k--) begin
        if (kw_match[k] && (32'(lex_count) == kts_pkg::KW_LEN[k])) begin
          word_kind = 4'(k + 1);
        end
      end
    end
  end

  always_comb begin
    mode_next      = mode;
    kw_match_next  = kw_match;
    lex_count_next = lex_count;
    line_cnt_next  = line_cnt;
    col_cnt_next   = col_cnt;
    tok_line_next  = tok_line;
    tok_col_next   = tok_col;
    have_a         = 1'b0;
    have_b         = 1'b0;

    res_a.token_kind    = word_kind;
    res_a.token_char    = 8'd0;
    res_a.start_line    = 16'(tok_line);
    res_a.start_column  = 16'(tok_col);
    res_a.lexeme_length = 8'(lex_count);
    res_a.last_of_run   = 1'b0;

    res_b.token_kind    = kts_pkg::KIND_CHAR;
    res_b.token_char    = char_code;
    res_b.start_line    = 16'(line_adv);
    res_b.start_column  = 16'(col_adv);
    res_b.lexeme_length = 8'd1;
    res_b.last_of_run   = 1'b1;

    if (step) begin
      if (end_of_input) begin
        have_a = word_open;
        have_b = 1'b1;
        res_b.token_kind    = kts_pkg::KIND_EOF;
        res_b.token_char    = 8'd0;
        res_b.start_line    = 16'(line_cnt);
        res_b.start_column  = 16'(pos_inc(col_cnt));
        res_b.lexeme_length = 8'd0;
        mode_next      = kts_pkg::MODE_START;
        kw_match_next  = kts_pkg::ALL_MATCH;
        lex_count_next = '0;
        line_cnt_next  = pos_clip(initial_line);
        col_cnt_next   = pos_clip(initial_column);
      end else begin
        line_cnt_next = line_adv;
        col_cnt_next  = col_adv;
        case (mode)
          kts_pkg::MODE_COMMENT: begin
            if (is_nl) mode_next = kts_pkg::MODE_START;
          end
          default: begin
            if (cont) begin
              kw_match_next  = ext_match;
              lex_count_next = ext_cnt;
            end else begin
              have_a         = word_open;
              mode_next      = kts_pkg::MODE_START;
              kw_match_next  = kts_pkg::ALL_MATCH;
              lex_count_next = '0;
              if (begin_word) begin
                mode_next      = (is_alpha || is_under) ? kts_pkg::MODE_IDENT
                                                        : kts_pkg::MODE_NUMBER;
                kw_match_next  = ext_match;
                lex_count_next = ext_cnt;
                tok_line_next  = line_adv;
                tok_col_next   = col_adv;
              end else if (is_hash) begin
                mode_next = kts_pkg::MODE_COMMENT;
              end else if (single) begin
                have_b = 1'b1;
              end
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    push.count             = {1'b0, have_a} + {1'b0, have_b};
    push.first             = have_a ? res_a : res_b;
    push.first.last_of_run = !(have_a && have_b);
    push.second            = res_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= kts_pkg::MODE_START;
      kw_match  <= kts_pkg::ALL_MATCH;
      lex_count <= '0;
      line_cnt  <= POS_W'(1);
      col_cnt   <= '0;
      tok_line  <= '0;
      tok_col   <= '0;
    end else begin
      mode      <= mode_next;
      kw_match  <= kw_match_next;
      lex_count <= lex_count_next;
      line_cnt  <= line_cnt_next;
      col_cnt   <= col_cnt_next;
      tok_line  <= tok_line_next;
      tok_col   <= tok_col_next;
    end
  end

endmodule

/* hw/rtl/kts_out_queue.sv */
// Small result queue: up to two writes, one read per cycle.
module kts_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  kts_pkg::push_t     push,
  input  logic               pop,
  output logic               not_empty,
  output logic               room,
  output kts_pkg::result_t   head
);

  localparam int unsigned DEPTH = kts_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  kts_pkg::result_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr, wr_ptr_1;
  logic [PTR_W:0]   count, count_next;

  assign wr_ptr_1   = wr_ptr + 1'b1;
  assign count_next = count + (PTR_W+1)'(push.count) - (PTR_W+1)'(pop);
  assign not_empty  = (count != '0);
  assign room       = (count <= (PTR_W+1)'(DEPTH - 2));
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entries[wr_ptr] <= push.first;
    if (push.count == 2'd2) entries[wr_ptr_1] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_W+1)'(DEPTH))
    else $error("result queue overflow");
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> room)
    else $error("push without room");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");
`endif

endmodule

/* hw/rtl/keyword_token_scanner_core.sv */
// Keyword token scanner: streaming lexer top level.
// Path: a word waits in the input register, then the scan logic writes its results
// into the result queue, from which they are offered.
// Throughput: one word per cycle while the queue has room; a word that ends a token
// and forms a punctuation token or eof queues two results, drained one per cycle.
// Reset (rst, synchronous): scanner at start, line 1, column 0, queue empty.
module keyword_token_scanner_core #(
  parameter int unsigned POSITION_BITS = kts_pkg::POSITION_BITS,
  parameter int unsigned LENGTH_MAX    = kts_pkg::LENGTH_MAX
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tuser,   // [0] end_of_input
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] token_char, [23:8] start_line,
                                 // [39:24] start_column, [47:40] lexeme_length
  output logic [3:0]  m_tuser,   // [3:0] token_kind
  output logic        m_tlast,   // last_of_run
  // config write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  // Config registers; they only load the counters at end of input.
  logic [15:0] initial_line;
  logic [15:0] initial_column;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_line   <= 16'd1;
      initial_column <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        kts_pkg::CFG_INITIAL_LINE:   initial_line   <= cfg_data;
        kts_pkg::CFG_INITIAL_COLUMN: initial_column <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: holds one word until the queue has room for two results.
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_eof;
  logic       room;
  logic       proceed;

  assign proceed  = in_valid && room;
  assign s_tready = !in_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_eof  <= s_tuser;
    end
  end

  kts_pkg::push_t   push;
  kts_pkg::result_t head;

  kts_scan #(
    .POS_W   (POSITION_BITS),
    .LEN_MAX (LENGTH_MAX)
  ) u_scan (
    .clk            (clk),
    .rst            (rst),
    .step           (proceed),
    .char_code      (in_char),
    .end_of_input   (in_eof),
    .initial_line   (initial_line),
    .initial_column (initial_column),
    .push           (push)
  );

  kts_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (m_tvalid && m_tready),
    .not_empty (m_tvalid),
    .room      (room),
    .head      (head)
  );

  assign m_tdata = {head.lexeme_length, head.start_column, head.start_line,
                    head.token_char};
  assign m_tuser = head.token_kind;
  assign m_tlast = head.last_of_run;

`ifndef SYNTHESIS
  a_results_need_word: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> proceed)
    else $error("result without a consumed word");
  a_at_most_two: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd3)
    else $error("more than two results per word");
  a_last_marks_pair: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> !push.first.last_of_run && push.second.last_of_run)
    else $error("bad last flag on result pair");
  a_last_marks_single: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd1 |-> push.first.last_of_run)
    else $error("bad last flag on single result");
  a_eof_closes_run: assert property (@(posedge clk) disable iff (rst)
    proceed && in_eof |->
      (push.count == 2'd1 && push.first.token_kind == kts_pkg::KIND_EOF) ||
      (push.count == 2'd2 && push.second.token_kind == kts_pkg::KIND_EOF))
    else $error("end of input without eof token");
`endif

endmodule
